FILE: src/ip_address_text_parser_core_assert.svh
// assertion macros used by the address text parser core
`ifndef IP_ADDRESS_TEXT_PARSER_CORE_ASSERT_SVH
`define IP_ADDRESS_TEXT_PARSER_CORE_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define IPP_ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never hold outside reset
`define IPP_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: src/ipp_pkg.sv
// types, codes and helpers for the address text parser
package ipp_pkg;

	localparam int unsigned NumGroups = 8;
	localparam int unsigned GroupW    = 16;

	typedef enum logic [1:0] {
		FAM_NONE  = 2'd0,
		FAM_V4    = 2'd1,
		FAM_V6    = 2'd2,
		FAM_UNSUP = 2'd3
	} family_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_UNSUP     = 2'd2,
		ST_MISSING   = 2'd3
	} status_t;

	localparam logic [7:0] ChDot   = 8'h2e;
	localparam logic [7:0] ChColon = 8'h3a;

	// one input item
	typedef struct packed {
		logic [7:0] character;
		logic [1:0] family;
		logic       last;
	} in_t;

	// one result item
	typedef struct packed {
		status_t     status;
		logic [63:0] address_high;
		logic [63:0] address_low;
	} out_t;

	typedef logic [NumGroups-1:0][GroupW-1:0] group_store_t;

	// parse state carried between characters
	typedef struct packed {
		logic [15:0] field_value;
		logic [2:0]  digit_count;
		logic [3:0]  field_count;
		logic [3:0]  gap_position;
		logic        gap_seen;
		logic        prev_sep;
		logic        error_seen;
		family_t     latched_family;
		logic        in_address;
	} state_t;

	// group store write request
	typedef struct packed {
		logic        en;
		logic [2:0]  idx;
		logic [15:0] data;
	} store_wr_t;

	// hex digit decode: bit 4 marks a valid digit, bits 3..0 its value
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'b0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

FILE: src/ip_address_text_parser_core.sv
// top level of the streaming IPv4 / IPv6 address text parser
//
//  channel | handshake             | payload            | direction
//  --------+-----------------------+--------------------+----------
//  char    | char_valid/char_ready | char_item (in_t)   | in
//  res     | res_valid/res_ready   | res_item (out_t)   | out
//
// one character per cycle, except that a last character waits while the result
// register is full; a character is registered, then the parse logic updates the
// state and, on the last character, loads the result register.
// reset clears the parse state and both valid flags; the group store holds
// no reset and is only read where the current text has written it.
// a stalled result only holds back the next last character.
`include "ip_address_text_parser_core_assert.svh"

module ip_address_text_parser_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          char_valid,
	output logic          char_ready,
	input  ipp_pkg::in_t  char_item,
	output logic          res_valid,
	input  logic          res_ready,
	output ipp_pkg::out_t res_item
);

	logic                  in_valid_s1;
	ipp_pkg::in_t          in_item_s1;
	ipp_pkg::state_t       state_q;
	ipp_pkg::state_t       state_nxt;
	ipp_pkg::group_store_t store_q;
	ipp_pkg::store_wr_t    store_wr;
	ipp_pkg::out_t         result;
	logic                  push_ready;
	logic                  advance;
	logic                  push_valid;
	logic                  last_s1;
	logic                  res_failed;
	logic                  res_addr_zero;

	// the registered item moves on unless it is a last one facing a full output
	assign advance    = in_valid_s1 && (!in_item_s1.last || push_ready);
	assign push_valid = advance && in_item_s1.last;
	assign char_ready = !in_valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (char_ready) begin
			in_valid_s1 <= char_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_valid && char_ready) begin
			in_item_s1 <= char_item;
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// group store
	always_ff @(posedge clk) begin
		if (advance && store_wr.en) begin
			store_q[store_wr.idx] <= store_wr.data;
		end
	end

	ipp_step u_step (
		.item      (in_item_s1),
		.state_cur (state_q),
		.store_cur (store_q),
		.state_nxt (state_nxt),
		.store_wr  (store_wr),
		.result    (result)
	);

	ipp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (result),
		.push_ready (push_ready),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

	// terms used by the checks below
	assign last_s1       = in_valid_s1 && in_item_s1.last;
	assign res_failed    = res_valid && (res_item.status != ipp_pkg::ST_OK);
	assign res_addr_zero = (res_item.address_high == 64'h0) && (res_item.address_low == 64'h0);

	// a last item held back by a full output stays registered
	`IPP_ASSERT_PROP(a_last_held, (last_s1 && !push_ready) |=> in_valid_s1, "last item dropped")
	// a new result only follows a last character
	`IPP_ASSERT_PROP(a_res_from_last, $rose(res_valid) |-> $past(last_s1), "stray result")
	// a character that is not last leaves the parser inside a text
	`IPP_ASSERT_PROP(a_in_text, (advance && !last_s1) |=> state_q.in_address, "text not opened")
	// a failed status carries a zero address
	`IPP_ASSERT_NEVER(a_fail_zero, res_failed && !res_addr_zero, "address on failed status")

endmodule

FILE: src/ipp_step.sv
// per-character parse step and end-of-text address assembly
module ipp_step (
	input  ipp_pkg::in_t          item,
	input  ipp_pkg::state_t       state_cur,
	input  ipp_pkg::group_store_t store_cur,
	output ipp_pkg::state_t       state_nxt,
	output ipp_pkg::store_wr_t    store_wr,
	output ipp_pkg::out_t         result
);

	always_comb begin
		ipp_pkg::state_t       st;
		ipp_pkg::store_wr_t    wr;
		ipp_pkg::group_store_t gs;
		ipp_pkg::group_store_t fgs;
		ipp_pkg::group_store_t g;
		ipp_pkg::out_t         res;
		logic [4:0]            hv;
		logic [11:0]           v12;
		logic [3:0]            ffc;
		logic [3:0]            tail;
		logic [4:0]            reach;
		logic                  is_dec;
		logic                  ok;

		st  = state_cur;
		wr  = '0;
		res = '0;
		g   = '0;
		ok  = 1'b0;
		tail  = '0;
		reach = '0;

		// first character of a text opens a fresh parse
		if (!st.in_address) begin
			st.field_value    = '0;
			st.digit_count    = '0;
			st.field_count    = '0;
			st.gap_position   = '0;
			st.gap_seen       = 1'b0;
			st.prev_sep       = 1'b0;
			st.error_seen     = 1'b0;
			st.latched_family = ipp_pkg::family_t'(item.family);
			st.in_address     = 1'b1;
		end

		is_dec = (item.character >= 8'h30) && (item.character <= 8'h39);
		hv     = ipp_pkg::hex_digit(item.character);
		v12    = {1'b0, st.field_value[7:0], 3'b000} + {3'b000, st.field_value[7:0], 1'b0}
		       + {8'h00, hv[3:0]};

		// classify the character
		if (!st.error_seen) begin
			case (st.latched_family)
				ipp_pkg::FAM_V4: begin
					if (is_dec) begin
						if (st.digit_count >= 3'd3 || v12 > 12'd255) begin
							st.error_seen = 1'b1;
						end else begin
							st.field_value = {8'h00, v12[7:0]};
							st.digit_count = st.digit_count + 3'd1;
						end
					end else if (item.character == ipp_pkg::ChDot) begin
						if (st.digit_count == 3'd0 || st.field_count >= 4'd3) begin
							st.error_seen = 1'b1;
						end else begin
							wr = '{en: 1'b1, idx: st.field_count[2:0], data: st.field_value};
							st.field_count = st.field_count + 4'd1;
							st.field_value = '0;
							st.digit_count = '0;
						end
					end else begin
						st.error_seen = 1'b1;
					end
				end
				ipp_pkg::FAM_V6: begin
					if (hv[4]) begin
						if (st.digit_count >= 3'd4 ||
						    (st.prev_sep && st.field_count == 4'd0 && !st.gap_seen)) begin
							st.error_seen = 1'b1;
						end else begin
							st.field_value = {st.field_value[11:0], hv[3:0]};
							st.digit_count = st.digit_count + 3'd1;
							st.prev_sep    = 1'b0;
						end
					end else if (item.character == ipp_pkg::ChColon) begin
						if (st.digit_count != 3'd0) begin
							if (st.field_count >= 4'd8) begin
								st.error_seen = 1'b1;
							end else begin
								wr = '{en: 1'b1, idx: st.field_count[2:0],
								       data: st.field_value};
								st.field_count = st.field_count + 4'd1;
								st.field_value = '0;
								st.digit_count = '0;
							end
							st.prev_sep = 1'b1;
						end else if (st.prev_sep) begin
							if (st.gap_seen) begin
								st.error_seen = 1'b1;
							end else begin
								st.gap_seen     = 1'b1;
								st.gap_position = st.field_count;
							end
						end else begin
							st.prev_sep = 1'b1;
						end
					end else begin
						st.error_seen = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end

		// store contents as seen by the closing step
		gs = store_cur;
		if (wr.en) begin
			gs[wr.idx] = wr.data;
		end

		// closing push of the open field
		fgs = gs;
		ffc = st.field_count;
		if (st.digit_count != 3'd0 && st.field_count < 4'd8) begin
			fgs[st.field_count[2:0]] = st.field_value;
			ffc = st.field_count + 4'd1;
		end

		case (st.latched_family)
			ipp_pkg::FAM_NONE:  res.status = ipp_pkg::ST_MISSING;
			ipp_pkg::FAM_UNSUP: res.status = ipp_pkg::ST_UNSUP;
			ipp_pkg::FAM_V4: begin
				ok = !st.error_seen && st.digit_count != 3'd0 && st.field_count == 4'd3;
				if (ok) begin
					res.address_low = {32'h0, fgs[0][7:0], fgs[1][7:0], fgs[2][7:0],
					                   fgs[3][7:0]};
				end
				res.status = ok ? ipp_pkg::ST_OK : ipp_pkg::ST_MALFORMED;
			end
			default: begin
				ok = !st.error_seen;
				if (st.digit_count != 3'd0) begin
					if (st.field_count >= 4'd8) begin
						ok = 1'b0;
					end
				end else if (!(st.gap_seen && st.prev_sep &&
				               st.gap_position == st.field_count)) begin
					ok = 1'b0;
				end
				if (st.gap_seen ? (ffc > 4'd7) : (ffc != 4'd8)) begin
					ok = 1'b0;
				end
				// expand the double colon into zero groups
				tail = ffc - st.gap_position;
				for (int k = 0; k < ipp_pkg::NumGroups; k++) begin
					if (st.gap_seen) begin
						reach = 5'(k) + {1'b0, tail};
						if (4'(k) < st.gap_position) begin
							g[k] = fgs[k];
						end
						if (reach >= 5'd8) begin
							g[k] = fgs[3'(k) + ffc[2:0]];
						end
					end else begin
						g[k] = fgs[k];
					end
				end
				if (ok) begin
					res.address_high = {g[0], g[1], g[2], g[3]};
					res.address_low  = {g[4], g[5], g[6], g[7]};
				end
				res.status = ok ? ipp_pkg::ST_OK : ipp_pkg::ST_MALFORMED;
			end
		endcase

		// last character ends the text
		if (item.last) begin
			st.in_address = 1'b0;
		end

		state_nxt = st;
		store_wr  = wr;
		result    = res;
	end

endmodule

FILE: src/ipp_out_stage.sv
// result register between the parse step and the result channel
module ipp_out_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  ipp_pkg::out_t push_item,
	output logic          push_ready,
	output logic          res_valid,
	input  logic          res_ready,
	output ipp_pkg::out_t res_item
);

	logic          valid_q;
	ipp_pkg::out_t item_q;

	// register accepts a new item when empty or being drained
	assign push_ready = !valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push_ready) begin
			valid_q <= push_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (push_valid && push_ready) begin
			item_q <= push_item;
		end
	end

	assign res_valid = valid_q;
	assign res_item  = item_q;

endmodule

FILE: verif/ip_address_text_parser_checker.sv
// watches both channels of the address text parser, predicts each result and compares
module ip_address_text_parser_checker
	import ipp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        char_valid,
	input  logic        char_ready,
	input  in_t         char_item,
	input  logic        res_valid,
	input  logic        res_ready,
	input  out_t        res_item,
	output int unsigned fail_count,
	output int unsigned pending,
	output int unsigned results_seen,
	output int unsigned parsed_ok
);
	timeunit 1ns;
	timeprecision 1ps;

	// predicted parse state of the text in progress
	logic [15:0] acc_value;
	logic [2:0]  acc_digits;
	logic [3:0]  n_groups;
	logic [15:0] groups [8];
	logic [3:0]  gap_at;
	logic        has_gap;
	logic        after_colon;
	logic        bad;
	family_t     text_family;
	logic        mid_text;

	// addresses still owed by the block, oldest first
	out_t expected_addr_q[$];

	function automatic void clear_text();
		acc_value   = '0;
		acc_digits  = '0;
		n_groups    = '0;
		for (int k = 0; k < 8; k++) groups[k] = '0;
		gap_at      = '0;
		has_gap     = 1'b0;
		after_colon = 1'b0;
		bad         = 1'b0;
	endfunction

	// close the current field or group
	function automatic void store_group();
		if (n_groups >= 8) begin
			bad = 1'b1;
			return;
		end
		groups[n_groups[2:0]] = acc_value;
		n_groups   = n_groups + 1'b1;
		acc_value  = '0;
		acc_digits = '0;
	endfunction

	// hex digit value, or -1 for anything else
	function automatic int hex_value(input logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c - "0");
		if (c >= "a" && c <= "f") return int'(c - "a") + 10;
		if (c >= "A" && c <= "F") return int'(c - "A") + 10;
		return -1;
	endfunction

	// dotted decimal character
	function automatic void take_v4(input logic [7:0] c);
		int unsigned v;
		if (c >= "0" && c <= "9") begin
			v = int'(acc_value) * 10 + int'(c - "0");
			if (acc_digits >= 3 || v > 255) begin
				bad = 1'b1;
				return;
			end
			acc_value  = v[15:0];
			acc_digits = acc_digits + 1'b1;
		end else if (c == ChDot) begin
			if (acc_digits == 0 || n_groups >= 3) begin
				bad = 1'b1;
				return;
			end
			store_group();
		end else begin
			bad = 1'b1;
		end
	endfunction

	// colon hex character
	function automatic void take_v6(input logic [7:0] c);
		int d;
		d = hex_value(c);
		if (d >= 0) begin
			if (acc_digits >= 4 || (after_colon && n_groups == 0 && !has_gap)) begin
				bad = 1'b1;
				return;
			end
			acc_value   = {acc_value[11:0], 4'(d)};
			acc_digits  = acc_digits + 1'b1;
			after_colon = 1'b0;
		end else if (c == ChColon) begin
			if (acc_digits > 0) begin
				store_group();
				after_colon = 1'b1;
			end else if (after_colon) begin
				if (has_gap) begin
					bad = 1'b1;
					return;
				end
				has_gap = 1'b1;
				gap_at  = n_groups;
			end else begin
				after_colon = 1'b1;
			end
		end else begin
			bad = 1'b1;
		end
	endfunction

	function automatic bit close_v4(output logic [63:0] lo);
		lo = '0;
		if (bad || acc_digits == 0 || n_groups != 3) return 1'b0;
		store_group();
		lo = {32'd0, groups[0][7:0], groups[1][7:0], groups[2][7:0], groups[3][7:0]};
		return 1'b1;
	endfunction

	// expand the double colon into zero groups
	function automatic bit close_v6(output logic [63:0] hi, output logic [63:0] lo);
		logic [15:0] g [8];
		int unsigned tail;
		hi = '0;
		lo = '0;
		if (bad) return 1'b0;
		if (acc_digits > 0) begin
			store_group();
			if (bad) return 1'b0;
		end else if (!(has_gap && after_colon && gap_at == n_groups)) begin
			return 1'b0;
		end
		if (has_gap ? (n_groups > 7) : (n_groups != 8)) return 1'b0;
		for (int k = 0; k < 8; k++) g[k] = '0;
		if (has_gap) begin
			tail = n_groups - gap_at;
			for (int k = 0; k < gap_at && k < 8; k++) g[k] = groups[k];
			for (int k = 0; k < tail; k++) g[(8 - tail + k) % 8] = groups[(gap_at + k) % 8];
		end else begin
			for (int k = 0; k < 8; k++) g[k] = groups[k];
		end
		hi = {g[0], g[1], g[2], g[3]};
		lo = {g[4], g[5], g[6], g[7]};
		return 1'b1;
	endfunction

	// one character in; returns 1 with the address item when the text ends
	function automatic bit parse_char(input in_t it, output out_t r);
		bit          ok;
		logic [63:0] hi;
		logic [63:0] lo;
		r = '0;
		if (!mid_text) begin
			clear_text();
			text_family = family_t'(it.family);
			mid_text    = 1'b1;
		end
		if (!bad) begin
			if (text_family == FAM_V4) take_v4(it.character);
			else if (text_family == FAM_V6) take_v6(it.character);
		end
		if (!it.last) return 1'b0;
		mid_text = 1'b0;
		case (text_family)
			FAM_NONE:  r.status = ST_MISSING;
			FAM_UNSUP: r.status = ST_UNSUP;
			default: begin
				if (text_family == FAM_V4) begin
					ok = close_v4(lo);
					hi = '0;
				end else begin
					ok = close_v6(hi, lo);
				end
				r.status = ok ? ST_OK : ST_MALFORMED;
				if (ok) begin
					r.address_high = hi;
					r.address_low  = lo;
				end
			end
		endcase
		return 1'b1;
	endfunction

	// predict on accepted characters, compare accepted results
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		out_t got;
		if (!arst_n) begin
			clear_text();
			text_family = FAM_NONE;
			mid_text    = 1'b0;
			expected_addr_q.delete();
			fail_count   = 0;
			pending      = 0;
			results_seen = 0;
			parsed_ok    = 0;
		end else begin
			if (char_valid && char_ready) begin
				if (parse_char(char_item, want)) expected_addr_q.push_back(want);
			end
			if (res_valid && res_ready) begin
				got = res_item;
				results_seen++;
				if (expected_addr_q.size() == 0) begin
					$error("result item with no text awaiting it: status %0d", got.status);
					fail_count++;
				end else begin
					want = expected_addr_q.pop_front();
					if (want.status == ST_OK) parsed_ok++;
					if (got.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, got.status);
						fail_count++;
					end
					if (got.address_high !== want.address_high) begin
						$error("address_high: expected %h, actual %h",
							want.address_high, got.address_high);
						fail_count++;
					end
					if (got.address_low !== want.address_low) begin
						$error("address_low: expected %h, actual %h",
							want.address_low, got.address_low);
						fail_count++;
					end
				end
			end
			pending = expected_addr_q.size();
		end
	end

endmodule

FILE: verif/testbench.sv
// top of the address text parser testbench: clock, reset, text stimulus and verdict
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import ipp_pkg::*;

	localparam int unsigned WatchdogLimit = 2000;
	localparam string       OddChars      = "0129afAFgG.: +-";

	logic clk        = 1'b0;
	logic arst_n     = 1'b0;
	logic char_valid = 1'b0;
	logic char_ready;
	in_t  char_item  = '0;
	logic res_valid;
	logic res_ready  = 1'b0;
	out_t res_item;

	int unsigned fail_count;
	int unsigned pending;
	int unsigned results_seen;
	int unsigned parsed_ok;

	bit          gaps_on = 1'b1;
	int unsigned chars_sent;
	int unsigned texts_v4;
	int unsigned texts_v6;
	int unsigned texts_other;
	int unsigned idle_cycles;

	// text being built before it is sent
	logic [7:0] text_q[$];

	always #1 clk = ~clk;

	ip_address_text_parser_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_item (char_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	ip_address_text_parser_checker parse_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.char_valid  (char_valid),
		.char_ready  (char_ready),
		.char_item   (char_item),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res_item    (res_item),
		.fail_count  (fail_count),
		.pending     (pending),
		.results_seen(results_seen),
		.parsed_ok   (parsed_ok)
	);

	// result side back-pressure
	always @(negedge clk) begin
		res_ready <= !gaps_on || ($urandom_range(99) >= 37);
	end

	// watchdog on cycles where no item moves
	always @(posedge clk) begin
		if (!arst_n || (char_valid && char_ready) || (res_valid && res_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog: no item moved for %0d cycles", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// one character, with random idle cycles before it
	task automatic send_char(input in_t it);
		while (gaps_on && $urandom_range(99) < 37) begin
			char_valid <= 1'b0;
			@(negedge clk);
		end
		char_valid <= 1'b1;
		char_item  <= it;
		do @(posedge clk); while (!char_ready);
		@(negedge clk);
		chars_sent++;
	endtask

	// family only counts on the first character, so the rest carry noise
	task automatic send_text(input family_t fam);
		in_t it;
		for (int i = 0; i < text_q.size(); i++) begin
			it.character = text_q[i];
			it.family    = (i == 0) ? fam : 2'($urandom_range(3));
			it.last      = (i == text_q.size() - 1);
			send_char(it);
		end
		if (fam == FAM_V4) texts_v4++;
		else if (fam == FAM_V6) texts_v6++;
		else texts_other++;
	endtask

	task automatic send_string(input string s, input family_t fam);
		text_q.delete();
		for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
		send_text(fam);
	endtask

	// any byte, or one of the characters the parser cares about
	function automatic logic [7:0] odd_char();
		if ($urandom_range(1)) return 8'($urandom_range(255));
		return OddChars[$urandom_range(OddChars.len() - 1)];
	endfunction

	// dotted decimal, sometimes zero padded, now and then a field over 255
	task automatic make_v4();
		for (int f = 0; f < 4; f++) begin
			int unsigned v, nd, sel, div;
			sel = $urandom_range(19);
			v   = (sel == 0) ? 0 : (sel == 1) ? 255 :
				(sel == 2) ? $urandom_range(999, 256) : $urandom_range(255);
			nd  = (v >= 100) ? 3 : (v >= 10) ? 2 : 1;
			if ($urandom_range(4) == 0) nd = $urandom_range(3, nd);
			div = 1;
			for (int i = 1; i < nd; i++) div *= 10;
			for (int i = 0; i < nd; i++) begin
				text_q.push_back(8'("0" + (v / div) % 10));
				div /= 10;
			end
			if (f < 3) text_q.push_back(ChDot);
		end
	endtask

	// one hex group in mixed case, sometimes with leading zeros
	task automatic add_group();
		int unsigned v, nd, sel, nib;
		sel = $urandom_range(9);
		v   = (sel == 0) ? 0 : (sel == 1) ? 16'hffff : $urandom_range(16'hffff);
		nd  = (v >= 16'h1000) ? 4 : (v >= 16'h100) ? 3 : (v >= 16'h10) ? 2 : 1;
		if ($urandom_range(3) == 0) nd = $urandom_range(4, nd);
		for (int i = nd - 1; i >= 0; i--) begin
			nib = (v >> (4 * i)) & 15;
			if (nib < 10) text_q.push_back(8'("0" + nib));
			else text_q.push_back(8'(($urandom_range(1) ? "A" : "a") + nib - 10));
		end
	endtask

	// colon hex, mostly with a double colon, rarely one group too many or few
	task automatic make_v6();
		int unsigned total, head;
		bit          gap;
		gap = ($urandom_range(2) != 0);
		if (gap) total = ($urandom_range(19) == 0) ? 8 : $urandom_range(7);
		else total = ($urandom_range(19) == 0) ? ($urandom_range(1) ? 7 : 9) : 8;
		head = gap ? $urandom_range(total) : total;
		for (int i = 0; i < head; i++) begin
			if (i > 0) text_q.push_back(ChColon);
			add_group();
		end
		if (gap) begin
			text_q.push_back(ChColon);
			text_q.push_back(ChColon);
			for (int i = head; i < total; i++) begin
				if (i > head) text_q.push_back(ChColon);
				add_group();
			end
		end
	endtask

	// damage a well-formed text in one or two places
	task automatic corrupt();
		int n;
		n = $urandom_range(2, 1);
		repeat (n) begin
			int pos, op;
			pos = $urandom_range(text_q.size() - 1);
			op  = $urandom_range(4);
			case (op)
				0: text_q[pos] = odd_char();
				1: if (text_q.size() > 1) text_q.delete(pos);
				2: text_q.insert(pos, odd_char());
				3: text_q.insert(pos, text_q[pos]);
				default: text_q.push_back(odd_char());
			endcase
		end
	endtask

	initial begin
		int unsigned kind;
		int unsigned len;
		family_t     fam;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: missing and unsupported family, extremes, broken forms
		send_string("x", FAM_NONE);
		send_string("y", FAM_UNSUP);
		send_string("::", FAM_V6);
		send_string("255.0.0.1", FAM_V4);
		send_string("256", FAM_V4);
		send_string(":::", FAM_V6);
		send_string(":1", FAM_V6);
		send_string("A.", FAM_V4);

		// random texts, mostly well formed, with a stretch of full throughput
		while (chars_sent < 1500) begin
			gaps_on = !(chars_sent >= 600 && chars_sent < 900);
			kind    = $urandom_range(99);
			text_q.delete();
			if (kind < 35) begin
				make_v4();
				fam = FAM_V4;
			end else if (kind < 65) begin
				make_v6();
				fam = FAM_V6;
			end else if (kind < 75) begin
				make_v4();
				corrupt();
				fam = FAM_V4;
			end else if (kind < 87) begin
				make_v6();
				corrupt();
				fam = FAM_V6;
			end else begin
				// noise or a good text under a random family
				if ($urandom_range(1)) begin
					len = $urandom_range(10, 1);
					repeat (len) text_q.push_back(odd_char());
				end else if ($urandom_range(1)) begin
					make_v4();
				end else begin
					make_v6();
				end
				fam = family_t'($urandom_range(3));
			end
			send_text(fam);
		end
		char_valid <= 1'b0;

		// drain outstanding results, then idle so that any stray result is seen
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d characters in %0d texts: %0d IPv4, %0d IPv6, %0d other family",
			chars_sent, texts_v4 + texts_v6 + texts_other, texts_v4, texts_v6, texts_other);
		$display("%0d results compared, %0d of them parsed to an address",
			results_seen, parsed_ok);
		if (fail_count == 0 && pending == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
